@@ hw/rtl/text_console_cell_engine_assert.svh @@
// Assertion macros for the console engine datapath.
`ifndef TEXT_CONSOLE_CELL_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CELL_ENGINE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define TCCE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// A property whose consequence must hold in the cycle after its trigger.
`define TCCE_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ hw/rtl/tcce_pkg.sv @@
package tcce_pkg;

    // Field widths of the command and result transactions.
    localparam int FUNC_W = 3;
    localparam int CHAR_W = 8;
    localparam int SGR_W  = 8;
    localparam int TCOL_W = 7;
    localparam int TROW_W = 5;
    localparam int OCOL_W = 7;
    localparam int OROW_W = 5;
    localparam int POS_W  = 11;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    // Command codes.
    localparam logic [FUNC_W-1:0] FUNC_PRINT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SGR   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MOVE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

    // Character codes with special handling.
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;

    // Attribute after reset and nibble masks.
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [ATTR_W-1:0] ATTR_FG    = 8'h0F;
    localparam logic [ATTR_W-1:0] ATTR_BG    = 8'hF0;

    // SGR parameter bases.
    localparam logic [SGR_W-1:0] SGR_RESET     = 8'd0;
    localparam logic [SGR_W-1:0] SGR_FG        = 8'd30;
    localparam logic [SGR_W-1:0] SGR_BG        = 8'd40;
    localparam logic [SGR_W-1:0] SGR_FG_BRIGHT = 8'd90;
    localparam logic [SGR_W-1:0] SGR_BG_BRIGHT = 8'd100;
    localparam logic [SGR_W-1:0] SGR_SPAN      = 8'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic fill_step;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_fill;
        logic is_read;
        logic fill_last;
        logic out_free;
    } t_dp_status;

    // ANSI color index to VGA color index.
    function automatic logic [3:0] ansi_to_vga(input logic [3:0] idx);
        logic [3:0] v;
        case (idx)
            4'd0:    v = 4'd0;
            4'd1:    v = 4'd4;
            4'd2:    v = 4'd2;
            4'd3:    v = 4'd6;
            4'd4:    v = 4'd1;
            4'd5:    v = 4'd5;
            4'd6:    v = 4'd3;
            4'd7:    v = 4'd7;
            4'd8:    v = 4'd8;
            4'd9:    v = 4'd12;
            4'd10:   v = 4'd10;
            4'd11:   v = 4'd14;
            4'd12:   v = 4'd9;
            4'd13:   v = 4'd13;
            4'd14:   v = 4'd11;
            default: v = 4'd15;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/tcce_if.sv @@
// Command channel: one console command per transaction.
interface tcce_cmd_if;
    import tcce_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [SGR_W-1:0]  sgr_code;
    logic [TCOL_W-1:0] target_col;
    logic [TROW_W-1:0] target_row;

    modport source (
        output valid, func, char_code, sgr_code, target_col, target_row,
        input  ready
    );
    modport sink (
        input  valid, func, char_code, sgr_code, target_col, target_row,
        output ready
    );
endinterface

// Result channel: one console status report per transaction.
interface tcce_res_if;
    import tcce_pkg::*;

    logic              valid;
    logic              ready;
    logic [OCOL_W-1:0] cursor_col;
    logic [OROW_W-1:0] cursor_row;
    logic [POS_W-1:0]  cursor_position;
    logic [ATTR_W-1:0] current_attribute;
    logic [CELL_W-1:0] cell_value;

    modport source (
        output valid, cursor_col, cursor_row, cursor_position, current_attribute,
               cell_value,
        input  ready
    );
    modport sink (
        input  valid, cursor_col, cursor_row, cursor_position, current_attribute,
               cell_value,
        output ready
    );
endinterface

@@ hw/rtl/text_console_cell_engine.sv @@
// Each command is captured, executed and its result loaded into the result register.
// Print, SGR, move and no-op load it in the execute state when the result register is free,
// a cell read in the done state behind the registered memory read port. A print that scrolls
// and a clear first sweep the blank row or screen, one cell per cycle on the write port.
// One command at a time: the next command is taken only after the result is loaded.
// Synchronous active-low reset; afterwards a clearing pass over all COLUMNS * ROWS cells.
module text_console_cell_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tcce_cmd_if.sink                     i_cmd,
    tcce_res_if.source                   o_res,
    input  logic                         i_cfg_we,
    input  logic [tcce_pkg::ATTR_W-1:0]  i_cfg_wdata
);
    import tcce_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       cmd_ready;

    // Sequencing of each command.
    tcce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (cmd_ready),
        .i_status    (dp_status),
        .o_dp_cmd    (dp_cmd)
    );

    assign i_cmd.ready = cmd_ready;

    // Screen memory, cursor and attribute state.
    tcce_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_dp_cmd            (dp_cmd),
        .o_status            (dp_status),
        .i_func              (i_cmd.func),
        .i_char_code         (i_cmd.char_code),
        .i_sgr_code          (i_cmd.sgr_code),
        .i_target_col        (i_cmd.target_col),
        .i_target_row        (i_cmd.target_row),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_res_ready         (o_res.ready),
        .o_res_valid         (o_res.valid),
        .o_cursor_col        (o_res.cursor_col),
        .o_cursor_row        (o_res.cursor_row),
        .o_cursor_position   (o_res.cursor_position),
        .o_current_attribute (o_res.current_attribute),
        .o_cell_value        (o_res.cell_value)
    );

endmodule

@@ hw/rtl/tcce_ctrl.sv @@
module tcce_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  tcce_pkg::t_dp_status  i_status,
    output tcce_pkg::t_dp_cmd     o_dp_cmd
);
    import tcce_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        case (r_state)
            ST_INIT: begin
                o_dp_cmd.fill_step = 1'b1;
                if (i_status.fill_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid && r_ready) begin
                    o_dp_cmd.capture = 1'b1;
                    n_state          = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_dp_cmd.exec = 1'b1;
                if (i_status.needs_fill) begin
                    n_state = ST_FILL;
                end else if (i_status.is_read) begin
                    n_state = ST_DONE;
                end else if (i_status.out_free) begin
                    o_dp_cmd.load_out = 1'b1;
                    n_state           = ST_IDLE;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_FILL: begin
                o_dp_cmd.fill_step = 1'b1;
                if (i_status.fill_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_dp_cmd.load_out = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered ready; reset starts the screen clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == ST_IDLE);
        end
    end

    assign o_cmd_ready = r_ready;

endmodule

@@ hw/rtl/tcce_datapath.sv @@
`include "text_console_cell_engine_assert.svh"

module tcce_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcce_pkg::t_dp_cmd             i_dp_cmd,
    output tcce_pkg::t_dp_status          o_status,
    input  logic [tcce_pkg::FUNC_W-1:0]   i_func,
    input  logic [tcce_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcce_pkg::SGR_W-1:0]    i_sgr_code,
    input  logic [tcce_pkg::TCOL_W-1:0]   i_target_col,
    input  logic [tcce_pkg::TROW_W-1:0]   i_target_row,
    input  logic                          i_cfg_we,
    input  logic [tcce_pkg::ATTR_W-1:0]   i_cfg_wdata,
    input  logic                          i_res_ready,
    output logic                          o_res_valid,
    output logic [tcce_pkg::OCOL_W-1:0]   o_cursor_col,
    output logic [tcce_pkg::OROW_W-1:0]   o_cursor_row,
    output logic [tcce_pkg::POS_W-1:0]    o_cursor_position,
    output logic [tcce_pkg::ATTR_W-1:0]   o_current_attribute,
    output logic [tcce_pkg::CELL_W-1:0]   o_cell_value
);
    import tcce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [CW:0]   COLS_X   = (CW + 1)'(COLUMNS);
    localparam logic [RW:0]   ROWS_X   = (RW + 1)'(ROWS);
    localparam logic [AW-1:0] CELL_END = AW'(CELLS - 1);
    localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
    localparam logic [AW-1:0] ROW_SPAN = AW'(COLUMNS - 1);

    // Captured command.
    logic [FUNC_W-1:0] r_func;
    logic [CHAR_W-1:0] r_char;
    logic [SGR_W-1:0]  r_sgr;
    logic [TCOL_W-1:0] r_tcol;
    logic [TROW_W-1:0] r_trow;

    // Console state; r_top is the physical row shown as the top line.
    logic [CW-1:0]     r_cur_col;
    logic [RW-1:0]     r_cur_row;
    logic [RW-1:0]     r_top;
    logic [ATTR_W-1:0] r_attr;
    logic [ATTR_W-1:0] r_def_attr;
    logic [CW-1:0]     n_cur_col;
    logic [RW-1:0]     n_cur_row;
    logic [RW-1:0]     n_top;
    logic [ATTR_W-1:0] n_attr;

    // Fill sweep.
    logic [AW-1:0] r_fill_addr;
    logic [AW-1:0] r_fill_end;
    logic          fill_last;

    // Screen memory.
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] r_rdata;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;

    // Result register.
    logic              r_out_valid;
    logic [OCOL_W-1:0] r_out_col;
    logic [OROW_W-1:0] r_out_row;
    logic [POS_W-1:0]  r_out_pos;
    logic [ATTR_W-1:0] r_out_attr;
    logic [CELL_W-1:0] r_out_cell;

    logic [8:0]    tcol_x;
    logic [6:0]    trow_x;
    logic [CW-1:0] clamp_col;
    logic [RW-1:0] clamp_row;
    logic [CW-1:0] a_col;
    logic [RW-1:0] a_row;
    logic [RW:0]   a_sum;
    logic [RW-1:0] a_phys;
    logic [AW-1:0] cell_addr;
    logic [AW-1:0] top_base;
    logic [CW:0]   col_w;
    logic [RW:0]   row_w;
    logic          print_store;
    logic          scroll;
    logic [SGR_W-1:0] sgr_off;
    logic [AW-1:0]    n_pos;

    // Clamp the target position of a move or read.
    always_comb begin
        tcol_x    = {2'b00, r_tcol};
        trow_x    = {2'b00, r_trow};
        clamp_col = (tcol_x >= 9'(COLUMNS)) ? COL_LAST : CW'(tcol_x);
        clamp_row = (trow_x >= 7'(ROWS)) ? ROW_LAST : RW'(trow_x);
    end

    // Cell address: logical row rotated by the scroll offset.
    always_comb begin
        a_col     = (r_func == FUNC_READ) ? clamp_col : r_cur_col;
        a_row     = (r_func == FUNC_READ) ? clamp_row : r_cur_row;
        a_sum     = {1'b0, a_row} + {1'b0, r_top};
        a_phys    = (a_sum >= ROWS_X) ? RW'(a_sum - ROWS_X) : RW'(a_sum);
        cell_addr = AW'(a_phys) * COLS_A + AW'(a_col);
        top_base  = AW'(r_top) * COLS_A;
    end

    // Cursor motion of a printed character.
    always_comb begin
        col_w       = {1'b0, r_cur_col};
        row_w       = {1'b0, r_cur_row};
        print_store = 1'b0;
        if (r_char == CHAR_NEWLINE) begin
            col_w = '0;
            row_w = row_w + 1'b1;
        end else if (r_char == CHAR_BACKSPACE) begin
            if (r_cur_col != '0) begin
                col_w = col_w - 1'b1;
            end else if (r_cur_row != '0) begin
                row_w = row_w - 1'b1;
                col_w = {1'b0, COL_LAST};
            end
        end else if (r_char != CHAR_RETURN) begin
            print_store = 1'b1;
            col_w       = col_w + 1'b1;
        end
        if (col_w == COLS_X) begin
            col_w = '0;
            row_w = row_w + 1'b1;
        end
        scroll = (row_w == ROWS_X);
        if (scroll) begin
            row_w = {1'b0, ROW_LAST};
        end
    end

    // Next console state.
    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_top     = r_top;
        n_attr    = r_attr;
        sgr_off   = '0;
        if (i_dp_cmd.exec) begin
            case (r_func)
                FUNC_PRINT: begin
                    n_cur_col = CW'(col_w);
                    n_cur_row = RW'(row_w);
                    if (scroll) begin
                        n_top = (r_top == ROW_LAST) ? '0 : r_top + 1'b1;
                    end
                end
                FUNC_SGR: begin
                    if (r_sgr == SGR_RESET) begin
                        n_attr = r_def_attr;
                    end else if (r_sgr >= SGR_FG && r_sgr <= SGR_FG + SGR_SPAN) begin
                        sgr_off = r_sgr - SGR_FG;
                        n_attr  = (r_attr & ATTR_BG)
                                | {4'h0, ansi_to_vga({1'b0, sgr_off[2:0]})};
                    end else if (r_sgr >= SGR_BG && r_sgr <= SGR_BG + SGR_SPAN) begin
                        sgr_off = r_sgr - SGR_BG;
                        n_attr  = (r_attr & ATTR_FG)
                                | {ansi_to_vga({1'b0, sgr_off[2:0]}), 4'h0};
                    end else if (r_sgr >= SGR_FG_BRIGHT
                                 && r_sgr <= SGR_FG_BRIGHT + SGR_SPAN) begin
                        sgr_off = r_sgr - SGR_FG_BRIGHT;
                        n_attr  = (r_attr & ATTR_BG)
                                | {4'h0, ansi_to_vga({1'b1, sgr_off[2:0]})};
                    end else if (r_sgr >= SGR_BG_BRIGHT
                                 && r_sgr <= SGR_BG_BRIGHT + SGR_SPAN) begin
                        sgr_off = r_sgr - SGR_BG_BRIGHT;
                        n_attr  = (r_attr & ATTR_FG)
                                | {ansi_to_vga({1'b1, sgr_off[2:0]}), 4'h0};
                    end
                end
                FUNC_MOVE: begin
                    n_cur_col = clamp_col;
                    n_cur_row = clamp_row;
                end
                default: begin
                end
            endcase
        end
        n_pos = AW'(n_cur_row) * COLS_A + AW'(n_cur_col);
    end

    // Capture the accepted command.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_func <= i_func;
            r_char <= i_char_code;
            r_sgr  <= i_sgr_code;
            r_tcol <= i_target_col;
            r_trow <= i_target_row;
        end
    end

    // Console state, configuration and fill sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_top       <= '0;
            r_attr      <= ATTR_RESET;
            r_def_attr  <= ATTR_RESET;
            r_fill_addr <= '0;
            r_fill_end  <= CELL_END;
        end else begin
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_top     <= n_top;
            r_attr    <= n_attr;
            if (i_cfg_we) begin
                r_def_attr <= i_cfg_wdata;
            end
            if (i_dp_cmd.exec && r_func == FUNC_CLEAR) begin
                r_fill_addr <= '0;
                r_fill_end  <= CELL_END;
            end else if (i_dp_cmd.exec && r_func == FUNC_PRINT && scroll) begin
                // The old top row becomes the new bottom line.
                r_fill_addr <= top_base;
                r_fill_end  <= top_base + ROW_SPAN;
            end else if (i_dp_cmd.fill_step && !fill_last) begin
                r_fill_addr <= r_fill_addr + 1'b1;
            end
        end
    end

    assign fill_last = (r_fill_addr == r_fill_end);

    // Memory write port: sweep writes blanks, print stores one character.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cell_addr;
        mem_wdata = {r_attr, r_char};
        if (i_dp_cmd.fill_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_fill_addr;
            mem_wdata = {r_attr, CHAR_BLANK};
        end else if (i_dp_cmd.exec && r_func == FUNC_PRINT && print_store) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[cell_addr];
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_out) begin
            r_out_col  <= OCOL_W'(n_cur_col);
            r_out_row  <= OROW_W'(n_cur_row);
            r_out_pos  <= POS_W'(n_pos);
            r_out_attr <= n_attr;
            r_out_cell <= (r_func == FUNC_READ) ? r_rdata : '0;
        end
    end

    assign o_status.needs_fill = (r_func == FUNC_CLEAR) || (r_func == FUNC_PRINT && scroll);
    assign o_status.is_read    = (r_func == FUNC_READ);
    assign o_status.fill_last  = fill_last;
    assign o_status.out_free   = !r_out_valid || i_res_ready;

    assign o_res_valid         = r_out_valid;
    assign o_cursor_col        = r_out_col;
    assign o_cursor_row        = r_out_row;
    assign o_cursor_position   = r_out_pos;
    assign o_current_attribute = r_out_attr;
    assign o_cell_value        = r_out_cell;

    // Cursor and scroll offset stay on the screen.
    `TCCE_ASSERT_ALWAYS(a_col_range, i_clk, i_rst_n, r_cur_col <= COL_LAST, "cursor column out of range")
    `TCCE_ASSERT_ALWAYS(a_row_range, i_clk, i_rst_n, r_cur_row <= ROW_LAST, "cursor row out of range")
    `TCCE_ASSERT_ALWAYS(a_top_range, i_clk, i_rst_n, r_top <= ROW_LAST, "scroll offset out of range")
    // Outside reset, the sweep walks one cell per step until its last cell.
    `TCCE_ASSERT_NEXT(a_fill_walk, i_clk, i_rst_n, i_rst_n && i_dp_cmd.fill_step && !fill_last, r_fill_addr == AW'($past(r_fill_addr) + 1'b1), "fill sweep skipped a cell")

endmodule

@@ tb/tcce_console_checker.sv @@
`timescale 1ns / 100ps

// Watches the command and result channels of the console engine, keeps its own
// copy of the screen, cursor and attributes, and compares every result.
module tcce_console_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tcce_cmd_if                         i_cmd,
    tcce_res_if                         i_res,
    input  logic                        i_cfg_we,
    input  logic [tcce_pkg::ATTR_W-1:0] i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    import tcce_pkg::*;

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int REPORT_CAP = 100;

    // VGA color for each ANSI color index, index 0 in the low nibble.
    localparam logic [63:0] VGA_OF_ANSI = 64'hFBD9_EAC8_7351_6240;

    typedef struct packed {
        logic [OCOL_W-1:0] col;
        logic [OROW_W-1:0] row;
        logic [POS_W-1:0]  pos;
        logic [ATTR_W-1:0] attr;
        logic [CELL_W-1:0] cell_val;
    } t_console_report;

    logic [CELL_W-1:0] screen [CELLS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [ATTR_W-1:0] text_attr;
    logic [ATTR_W-1:0] default_attr;
    t_console_report   expected_reports [$];
    int                mismatches = 0;

    function automatic logic [CELL_W-1:0] blank_cell();
        return {text_attr, CHAR_BLANK};
    endfunction

    function automatic void fill_screen();
        logic [CELL_W-1:0] blank;
        blank = blank_cell();
        for (int i = 0; i < CELLS; i++) screen[i] = blank;
    endfunction

    // Move every row up by one and blank the bottom row.
    function automatic void scroll_up();
        logic [CELL_W-1:0] blank;
        blank = blank_cell();
        for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = blank;
    endfunction

    function automatic void reset_console();
        default_attr = ATTR_RESET;
        text_attr    = ATTR_RESET;
        cur_col      = 0;
        cur_row      = 0;
        fill_screen();
    endfunction

    // Terminal behavior of one character, including wrap and scroll.
    function automatic void print_character(logic [CHAR_W-1:0] ch);
        if (ch == CHAR_NEWLINE) begin
            cur_col = 0;
            cur_row++;
        end else if (ch == CHAR_BACKSPACE) begin
            // Backspace moves without erasing and stops at the top left corner.
            if (cur_col != 0) begin
                cur_col--;
            end else if (cur_row != 0) begin
                cur_row--;
                cur_col = COLUMNS - 1;
            end
        end else if (ch != CHAR_RETURN) begin
            screen[cur_row * COLUMNS + cur_col] = {text_attr, ch};
            cur_col++;
        end
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        while (cur_row >= ROWS) begin
            scroll_up();
            cur_row--;
        end
    endfunction

    function automatic logic [3:0] vga_color(logic [3:0] ansi);
        return VGA_OF_ANSI[ansi * 4 +: 4];
    endfunction

    // SGR parameters; anything outside reset and the four color ranges is ignored.
    function automatic void apply_color(logic [SGR_W-1:0] code);
        if (code == SGR_RESET) begin
            text_attr = default_attr;
        end else if (code >= SGR_FG && code <= SGR_FG + SGR_SPAN) begin
            text_attr[3:0] = vga_color(4'(code - SGR_FG));
        end else if (code >= SGR_BG && code <= SGR_BG + SGR_SPAN) begin
            text_attr[7:4] = vga_color(4'(code - SGR_BG));
        end else if (code >= SGR_FG_BRIGHT && code <= SGR_FG_BRIGHT + SGR_SPAN) begin
            text_attr[3:0] = vga_color(4'(code - SGR_FG_BRIGHT) | 4'b1000);
        end else if (code >= SGR_BG_BRIGHT && code <= SGR_BG_BRIGHT + SGR_SPAN) begin
            text_attr[7:4] = vga_color(4'(code - SGR_BG_BRIGHT) | 4'b1000);
        end
    endfunction

    function automatic int unsigned clamp_col(logic [TCOL_W-1:0] v);
        return (v >= COLUMNS) ? COLUMNS - 1 : int'(v);
    endfunction

    function automatic int unsigned clamp_row(logic [TROW_W-1:0] v);
        return (v >= ROWS) ? ROWS - 1 : int'(v);
    endfunction

    // Runs one command on the model state and returns the status it reports.
    function automatic t_console_report run_command(
        logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] ch, logic [SGR_W-1:0] code,
        logic [TCOL_W-1:0] col, logic [TROW_W-1:0] row);
        t_console_report rep;
        rep.cell_val = '0;
        case (f)
            FUNC_PRINT: print_character(ch);
            FUNC_SGR:   apply_color(code);
            FUNC_MOVE: begin
                cur_col = clamp_col(col);
                cur_row = clamp_row(row);
            end
            FUNC_CLEAR: fill_screen();
            FUNC_READ:  rep.cell_val = screen[clamp_row(row) * COLUMNS + clamp_col(col)];
            default: ;
        endcase
        rep.col  = OCOL_W'(cur_col);
        rep.row  = OROW_W'(cur_row);
        rep.pos  = POS_W'(cur_row * COLUMNS + cur_col);
        rep.attr = text_attr;
        return rep;
    endfunction

    // Later mismatches are only counted, to keep the log readable.
    function automatic void check_field(string name, logic [CELL_W-1:0] want,
                                        logic [CELL_W-1:0] got);
        if (got !== want) begin
            if (mismatches < REPORT_CAP)
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Results are compared before the command of the same edge is modeled,
    // since a result never belongs to a command accepted at the same edge.
    always @(posedge i_clk) begin : track
        t_console_report want;
        if (!i_rst_n) begin
            reset_console();
            expected_reports.delete();
        end else begin
            if (i_cfg_we) default_attr = i_cfg_wdata;
            if (i_res.valid && i_res.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result transaction with no command waiting for it");
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("cursor_col", want.col, i_res.cursor_col);
                    check_field("cursor_row", want.row, i_res.cursor_row);
                    check_field("cursor_position", want.pos, i_res.cursor_position);
                    check_field("current_attribute", want.attr, i_res.current_attribute);
                    check_field("cell_value", want.cell_val, i_res.cell_value);
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                expected_reports.push_back(run_command(i_cmd.func, i_cmd.char_code,
                                                       i_cmd.sgr_code, i_cmd.target_col,
                                                       i_cmd.target_row));
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/text_console_cell_engine_test.sv @@
`timescale 1ns / 100ps

module text_console_cell_engine_test;
    import tcce_pkg::*;

    localparam int COLUMNS         = 80;
    localparam int ROWS            = 25;
    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 9;
    localparam int ATTR_PHASES     = 5;
    localparam int PHASE_ITEMS     = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 16;
    localparam int LIMIT_CYCLES    = 20_000_000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [ATTR_W-1:0] cfg_wdata;
    int                fail_count;
    int                pending_reports;
    bit                steady_stretch   = 1'b0;
    bit                hold_off_request = 1'b0;
    int                items_sent       = 0;
    int                attr_settings    = 1;
    int                func_seen [8];

    tcce_cmd_if cmd_if ();
    tcce_res_if res_if ();

    text_console_cell_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd       (cmd_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    tcce_console_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) screen_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_reports)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Offers one command, idling first at random, and waits for its transaction.
    task automatic send_command(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                                input logic [SGR_W-1:0] code, input logic [TCOL_W-1:0] col,
                                input logic [TROW_W-1:0] row);
        if (!steady_stretch) begin
            while ($urandom_range(0, 99) < 20) begin
                cmd_if.valid <= 1'b0;
                @(posedge clk);
            end
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.func       <= f;
        cmd_if.char_code  <= ch;
        cmd_if.sgr_code   <= code;
        cmd_if.target_col <= col;
        cmd_if.target_row <= row;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        items_sent++;
        func_seen[f]++;
    endtask

    // Command helpers; the fields a command does not use carry random bits.
    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_command(FUNC_PRINT, ch, SGR_W'($urandom), TCOL_W'($urandom), TROW_W'($urandom));
    endtask

    task automatic set_color(input logic [SGR_W-1:0] code);
        send_command(FUNC_SGR, CHAR_W'($urandom), code, TCOL_W'($urandom), TROW_W'($urandom));
    endtask

    task automatic goto_cell(input logic [TCOL_W-1:0] col, input logic [TROW_W-1:0] row);
        send_command(FUNC_MOVE, CHAR_W'($urandom), SGR_W'($urandom), col, row);
    endtask

    task automatic peek_cell(input logic [TCOL_W-1:0] col, input logic [TROW_W-1:0] row);
        send_command(FUNC_READ, CHAR_W'($urandom), SGR_W'($urandom), col, row);
    endtask

    task automatic wipe();
        send_command(FUNC_CLEAR, CHAR_W'($urandom), SGR_W'($urandom), TCOL_W'($urandom),
                     TROW_W'($urandom));
    endtask

    // Stops offering commands until every result has come back.
    task automatic wait_for_drain();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_reports != 0) @(posedge clk);
    endtask

    task automatic write_default_attr(input logic [ATTR_W-1:0] value);
        wait_for_drain();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        attr_settings++;
    endtask

    // Mostly printable text, with the control characters mixed in.
    function automatic logic [CHAR_W-1:0] text_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return CHAR_W'($urandom_range(CHAR_BLANK, "~"));
        if (pick < 80) return CHAR_NEWLINE;
        if (pick < 86) return CHAR_BACKSPACE;
        if (pick < 90) return CHAR_RETURN;
        return CHAR_W'($urandom);
    endfunction

    // SGR parameters: the color ranges, reset, near misses and random bytes.
    function automatic logic [SGR_W-1:0] color_code();
        logic [SGR_W-1:0] base;
        case ($urandom_range(0, 3))
            0:       base = SGR_FG;
            1:       base = SGR_BG;
            2:       base = SGR_FG_BRIGHT;
            default: base = SGR_BG_BRIGHT;
        endcase
        case ($urandom_range(0, 9))
            0:       return SGR_RESET;
            8:       return $urandom_range(0, 1) ? base - 8'd1 : base + SGR_SPAN + 8'd1;
            9:       return SGR_W'($urandom);
            default: return base + SGR_W'($urandom_range(0, SGR_SPAN));
        endcase
    endfunction

    // One random burst of related commands.
    task automatic random_burst();
        int pick;
        int len;
        int c;
        int r;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            // A run of terminal text.
            len = $urandom_range(1, 24);
            repeat (len) put_char(text_byte());
        end else if (pick < 55) begin
            // A short word at a known spot, read back cell by cell.
            c   = $urandom_range(0, COLUMNS - 1);
            r   = $urandom_range(0, ROWS - 1);
            len = $urandom_range(1, 6);
            goto_cell(TCOL_W'(c), TROW_W'(r));
            repeat (len) put_char(CHAR_W'($urandom_range("!", "~")));
            for (int i = 0; i < len; i++) peek_cell(TCOL_W'(c + i), TROW_W'(r));
        end else if (pick < 70) begin
            // Color changes, then text in the new colors.
            len = $urandom_range(1, 3);
            repeat (len) set_color(color_code());
            len = $urandom_range(1, 8);
            repeat (len) put_char(text_byte());
        end else if (pick < 85) begin
            // Reads, often near the bottom where the text scrolls through.
            len = $urandom_range(1, 4);
            repeat (len) begin
                if ($urandom_range(0, 4) == 0)
                    peek_cell(TCOL_W'($urandom), TROW_W'($urandom));
                else if ($urandom_range(0, 1) == 0)
                    peek_cell(TCOL_W'($urandom_range(0, COLUMNS - 1)),
                              TROW_W'($urandom_range(ROWS - 5, ROWS - 1)));
                else
                    peek_cell(TCOL_W'($urandom_range(0, COLUMNS - 1)),
                              TROW_W'($urandom_range(0, ROWS - 1)));
            end
        end else if (pick < 93) begin
            // Cursor moves, some far outside the screen.
            if ($urandom_range(0, 3) == 0)
                goto_cell(TCOL_W'($urandom), TROW_W'($urandom));
            else
                goto_cell(TCOL_W'($urandom_range(0, COLUMNS - 1)),
                          TROW_W'($urandom_range(0, ROWS - 1)));
        end else if (pick < 99) begin
            // Noise: every field random, the unused command codes included.
            send_command(FUNC_W'($urandom), CHAR_W'($urandom), SGR_W'($urandom),
                         TCOL_W'($urandom), TROW_W'($urandom));
        end else begin
            wipe();
        end
    endtask

    // Result side: random stalls, one long hold-off on request.
    initial begin : result_sink
        res_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_request && rst_n) begin
                res_if.ready <= 1'b0;
                for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
                hold_off_request = 1'b0;
            end else begin
                res_if.ready <= rst_n && (steady_stretch || $urandom_range(0, 99) >= 20);
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int  phase_start;
        bit  paused;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        cmd_if.valid      = 1'b0;
        cmd_if.func       = '0;
        cmd_if.char_code  = '0;
        cmd_if.sgr_code   = '0;
        cmd_if.target_col = '0;
        cmd_if.target_row = '0;
        paused            = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset contents, character extremes and control characters.
        peek_cell('0, '0);
        put_char("A");
        put_char('1);
        put_char('0);
        put_char(CHAR_RETURN);
        put_char(CHAR_BACKSPACE);
        put_char(CHAR_NEWLINE);
        // Backspace at column 0 goes to the end of the row above.
        put_char(CHAR_BACKSPACE);
        // Backspace at the top left corner does nothing.
        goto_cell('0, '0);
        put_char(CHAR_BACKSPACE);
        // Color range edges, an unsupported code and the largest code.
        set_color(SGR_FG);
        set_color(SGR_FG + SGR_SPAN);
        set_color(SGR_BG);
        set_color(SGR_BG_BRIGHT + SGR_SPAN);
        set_color(SGR_FG_BRIGHT);
        set_color(SGR_FG + SGR_SPAN + 8'd1);
        set_color('1);
        // Clamped move to the last cell; printing there wraps and scrolls.
        goto_cell('1, '1);
        put_char("Z");
        peek_cell(TCOL_W'(COLUMNS - 1), TROW_W'(ROWS - 2));
        peek_cell('1, '1);
        put_char(CHAR_NEWLINE);
        set_color(SGR_RESET);
        wipe();
        peek_cell('0, '0);
        send_command('1, CHAR_W'($urandom), SGR_W'($urandom), TCOL_W'($urandom),
                     TROW_W'($urandom));

        // Random phases, each under its own default attribute.
        for (int phase = 0; phase < ATTR_PHASES; phase++) begin
            if (phase == 1)
                write_default_attr('0);
            else if (phase == 2)
                write_default_attr('1);
            else if (phase > 2)
                write_default_attr(ATTR_W'($urandom));
            if (phase > 0) set_color(SGR_RESET);
            steady_stretch = (phase == 1);
            if (phase == 2) hold_off_request = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if (phase == 3 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
                    wait_for_drain();
                    paused = 1'b1;
                end
                random_burst();
            end
        end
        steady_stretch = 1'b0;

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d commands: %0d prints, %0d color codes, %0d moves, %0d clears,",
                 items_sent, func_seen[FUNC_PRINT], func_seen[FUNC_SGR], func_seen[FUNC_MOVE],
                 func_seen[FUNC_CLEAR]);
        $display("%0d reads and %0d unused codes, under %0d default attribute settings.",
                 func_seen[FUNC_READ],
                 items_sent - func_seen[FUNC_PRINT] - func_seen[FUNC_SGR]
                 - func_seen[FUNC_MOVE] - func_seen[FUNC_CLEAR] - func_seen[FUNC_READ],
                 attr_settings);
        if (fail_count == 0 && pending_reports == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
